/* rtl/core/utf16_to_utf8_length_counter_macros.svh */
// Assertion macros used by the UTF-16 to UTF-8 length counter checker
`ifndef UTF16_TO_UTF8_LENGTH_COUNTER_MACROS_SVH
`define UTF16_TO_UTF8_LENGTH_COUNTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define U16L_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("u16l assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define U16L_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("u16l assertion failed");

`endif

/* rtl/core/u16l_pkg.sv */
// Shared types and constants of the UTF-16 to UTF-8 length counter
`timescale 1ns / 1ps
`default_nettype none

package u16l_pkg;

  // Geometry
  localparam int LANES     = 4;
  localparam int UNIT_W    = 16;
  localparam int VCNT_W    = 3;
  localparam int COUNT_W   = 34;
  localparam int ADD_W     = 2;
  localparam int SUM_W     = $clog2(3 * LANES + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Configuration register indices
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_BYTES       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_MODE = CFG_IDX_W'(1);

  // Code unit classification masks
  localparam logic [UNIT_W-1:0] MASK_ASCII  = 16'hff80;
  localparam logic [UNIT_W-1:0] MASK_TWO    = 16'hf800;
  localparam logic [UNIT_W-1:0] MASK_PAIR   = 16'hfc00;
  localparam logic [UNIT_W-1:0] SURR_BASE   = 16'hd800;
  localparam logic [UNIT_W-1:0] LOW_BASE    = 16'hdc00;

  // Input transaction
  typedef struct packed {
    logic [UNIT_W-1:0] unit_lane0;
    logic [UNIT_W-1:0] unit_lane1;
    logic [UNIT_W-1:0] unit_lane2;
    logic [UNIT_W-1:0] unit_lane3;
    logic [VCNT_W-1:0] valid_units;
    logic              message_end;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    logic [COUNT_W-1:0] utf8_bytes;
    logic               saturated;
  } out_item_t;

  // Per-lane finding handed to the merge stage
  typedef struct packed {
    logic [ADD_W-1:0] add;
    logic             is_high;
  } lane_res_t;

endpackage

`default_nettype wire

/* rtl/core/u16l_lane.sv */
// One lane: classifies a UTF-16 code unit into its UTF-8 byte cost
`timescale 1ns / 1ps
`default_nettype none

module u16l_lane (
  input  wire logic [u16l_pkg::UNIT_W-1:0] unit_i,
  input  wire logic                        swap_i,
  input  wire logic                        repl_i,
  input  wire logic                        prev_high_i,
  output u16l_pkg::lane_res_t              res_o
);

  logic [u16l_pkg::UNIT_W-1:0] u;
  logic                        is_surr;
  logic                        is_low;

  // Optional byte swap ahead of classification
  assign u = swap_i ? {unit_i[7:0], unit_i[15:8]} : unit_i;

  assign is_surr = (u & u16l_pkg::MASK_TWO) == u16l_pkg::SURR_BASE;
  assign is_low  = (u & u16l_pkg::MASK_PAIR) == u16l_pkg::LOW_BASE;

  // Byte cost; in replacement mode a low surrogate completing a pair nets one byte
  always_comb begin
    if ((u & u16l_pkg::MASK_ASCII) == '0) begin
      res_o.add = 2'd1;
    end else if ((u & u16l_pkg::MASK_TWO) == '0) begin
      res_o.add = 2'd2;
    end else if (is_surr && !repl_i) begin
      res_o.add = 2'd2;
    end else if (is_surr && prev_high_i && is_low) begin
      res_o.add = 2'd1;
    end else begin
      res_o.add = 2'd3;
    end
    res_o.is_high = (u & u16l_pkg::MASK_PAIR) == u16l_pkg::SURR_BASE;
  end

endmodule

`default_nettype wire

/* rtl/core/u16l_merge.sv */
// Merge stage: sums the lane costs into the saturating running count
`timescale 1ns / 1ps
`default_nettype none

module u16l_merge (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      accept_i,
  input  wire logic                                      msg_end_i,
  input  wire logic [u16l_pkg::VCNT_W-1:0]               valid_units_i,
  input  u16l_pkg::lane_res_t [u16l_pkg::LANES-1:0]      lanes_i,
  output logic                                           prev_high_o,
  output u16l_pkg::out_item_t                            res_o
);

  logic [u16l_pkg::COUNT_W-1:0] running_q, running_d;
  logic                         prev_high_q, prev_high_d;
  logic                         sat_q, sat_d;

  logic [u16l_pkg::VCNT_W-1:0]  vcnt;
  logic [u16l_pkg::SUM_W-1:0]   sum;
  logic                         last_high;
  logic [u16l_pkg::COUNT_W:0]   total;
  logic                         sat_hit;

  // Clamp the unit count to the lane count
  assign vcnt = (valid_units_i > u16l_pkg::VCNT_W'(u16l_pkg::LANES)) ?
                u16l_pkg::VCNT_W'(u16l_pkg::LANES) : valid_units_i;

  // Add the costs of the live lanes, pick the last live lane's high flag
  always_comb begin
    sum       = '0;
    last_high = prev_high_q;
    for (int i = 0; i < u16l_pkg::LANES; i++) begin
      if (u16l_pkg::VCNT_W'(i) < vcnt) begin
        sum = sum + u16l_pkg::SUM_W'(lanes_i[i].add);
      end
      if (vcnt == u16l_pkg::VCNT_W'(i + 1)) begin
        last_high = lanes_i[i].is_high;
      end
    end
  end

  // Saturating update; reaching the maximum sets the flag
  assign total   = {1'b0, running_q} + (u16l_pkg::COUNT_W + 1)'(sum);
  assign sat_hit = (vcnt != '0) && (total >= {1'b0, u16l_pkg::COUNT_MAX});

  always_comb begin
    res_o.utf8_bytes = running_q;
    if (sat_hit) begin
      res_o.utf8_bytes = u16l_pkg::COUNT_MAX;
    end else if (vcnt != '0) begin
      res_o.utf8_bytes = total[u16l_pkg::COUNT_W-1:0];
    end
    res_o.saturated = sat_q | sat_hit;
  end

  // Next state: cleared at the end of a message
  always_comb begin
    running_d   = running_q;
    prev_high_d = prev_high_q;
    sat_d       = sat_q;
    if (accept_i) begin
      if (msg_end_i) begin
        running_d   = '0;
        prev_high_d = 1'b0;
        sat_d       = 1'b0;
      end else begin
        running_d   = res_o.utf8_bytes;
        prev_high_d = last_high;
        sat_d       = res_o.saturated;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= '0;
      prev_high_q <= 1'b0;
      sat_q       <= 1'b0;
    end else begin
      running_q   <= running_d;
      prev_high_q <= prev_high_d;
      sat_q       <= sat_d;
    end
  end

  assign prev_high_o = prev_high_q;

endmodule

`default_nettype wire

/* rtl/core/utf16_to_utf8_length_counter.sv */
// UTF-16 to UTF-8 length counter: top level
//
// Usage:
//   The input channel (in_valid_i / in_stall_o / in_data_i) takes one
//   transaction of up to four UTF-16 code units a cycle, with a count of
//   live lanes and a message end flag. Four lanes classify the units side
//   by side and a merge stage adds their costs into a saturating 34-bit
//   running count in the same cycle.
//   The transaction that ends a message produces one output transaction
//   (out_valid_o / out_stall_i / out_data_o) with the total and the
//   saturation flag, in the cycle after it is taken; others produce nothing.
//   Throughput is one transaction per cycle, set by the count update loop
//   in the merge stage, while no message end is stalled.
//   While a result waits under out_stall_i, transactions that do not end a
//   message are still taken; one that ends a message is stalled.
//   The configuration channel (cfg_valid_i / cfg_ready_o) is always ready;
//   write it only while the block is idle.
//   Reset clears the count, the pair tracking and the output valid flag,
//   and sets byte swapping off and replacement mode on.
`timescale 1ns / 1ps
`default_nettype none

module utf16_to_utf8_length_counter (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  u16l_pkg::in_item_t                      in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output u16l_pkg::out_item_t                     out_data_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [u16l_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic                               cfg_data_i
);

  logic                                      swap_q, repl_q;
  logic                                      out_valid_q;
  u16l_pkg::out_item_t                       out_data_q;
  logic                                      accept;
  logic                                      prev_high;
  logic [u16l_pkg::UNIT_W-1:0]               units [u16l_pkg::LANES];
  logic [u16l_pkg::LANES-1:0]                lane_prev;
  u16l_pkg::lane_res_t [u16l_pkg::LANES-1:0] lanes;
  u16l_pkg::out_item_t                       res;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q <= 1'b0;
      repl_q <= 1'b1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == u16l_pkg::REG_SWAP_BYTES) begin
        swap_q <= cfg_data_i;
      end else if (cfg_index_i == u16l_pkg::REG_REPLACEMENT_MODE) begin
        repl_q <= cfg_data_i;
      end
    end
  end

  // Only a message end needs room in the output register
  assign in_stall_o = out_valid_q && out_stall_i && in_data_i.message_end;
  assign accept     = in_valid_i && !in_stall_o;

  assign units[0] = in_data_i.unit_lane0;
  assign units[1] = in_data_i.unit_lane1;
  assign units[2] = in_data_i.unit_lane2;
  assign units[3] = in_data_i.unit_lane3;

  // Lanes; each sees whether its predecessor was a high surrogate
  for (genvar g = 0; g < u16l_pkg::LANES; g++) begin : g_lane
    if (g == 0) begin : g_first
      assign lane_prev[g] = prev_high;
    end else begin : g_rest
      assign lane_prev[g] = lanes[g-1].is_high;
    end

    u16l_lane u_lane (
      .unit_i      (units[g]),
      .swap_i      (swap_q),
      .repl_i      (repl_q),
      .prev_high_i (lane_prev[g]),
      .res_o       (lanes[g])
    );
  end

  u16l_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .msg_end_i     (in_data_i.message_end),
    .valid_units_i (in_data_i.valid_units),
    .lanes_i       (lanes),
    .prev_high_o   (prev_high),
    .res_o         (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && in_data_i.message_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.message_end) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* rtl/core/u16l_checker.sv */
// Port-level checker for the UTF-16 to UTF-8 length counter, with its bind
`timescale 1ns / 1ps
`default_nettype none

`include "utf16_to_utf8_length_counter_macros.svh"

module u16l_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic                           in_stall_o,
  input  u16l_pkg::in_item_t                  in_data_i,
  input  wire logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  input  u16l_pkg::out_item_t                 out_data_o,
  input  wire logic                           cfg_valid_i,
  input  wire logic                           cfg_ready_o,
  input  wire logic [u16l_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic                           cfg_data_i
);

  logic acc_end;
  logic cfg_seen;

  assign acc_end  = in_valid_i && !in_stall_o && in_data_i.message_end;
  assign cfg_seen = cfg_valid_i && cfg_ready_o;

  // A stalled result holds
  `U16L_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o))

  // The saturation flag and the maximum count go together
  `U16L_ASSERT_IMPLY(a_sat_max, clk_i, rst_ni, out_valid_o,
    out_data_o.saturated == (out_data_o.utf8_bytes == u16l_pkg::COUNT_MAX))

  // A new result only follows a taken message end
  `U16L_ASSERT_IMPLY(a_out_cause, clk_i, rst_ni, $rose(out_valid_o), $past(acc_end))

  // An empty message right after another one counts zero bytes
  `U16L_ASSERT_NEXT(a_empty_zero, clk_i, rst_ni,
    acc_end && (in_data_i.valid_units == '0) && $past(acc_end),
    out_valid_o && (out_data_o.utf8_bytes == '0) && !out_data_o.saturated)

  // A register write carries a known index and value
  `U16L_ASSERT_IMPLY(a_cfg_known, clk_i, rst_ni, cfg_seen,
    !$isunknown(cfg_index_i) && !$isunknown(cfg_data_i))

endmodule

bind utf16_to_utf8_length_counter u16l_checker u_checker (.*);

`default_nettype wire
